@@ rtl/e2q_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and arithmetic helpers for the Euler angle to
// quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COMPONENT_BITS = 16;
  localparam int TRIG_STAGES    = 16;
  localparam int FRAC_BITS      = 30;

  // CORDIC datapath width (Q2.30 plus headroom), quaternion sum width
  localparam int CW = 33;
  localparam int QW = CW + 1;
  localparam int NW = 64;
  localparam int RW = NW / 2;
  localparam int SQRT_STAGES = NW / 2;
  localparam int QUO_BITS = COMPONENT_BITS + 1;
  localparam int DW = QW + COMPONENT_BITS + 1;

  localparam logic signed [CW-1:0] CORDIC_START = CW'(652032874);
  localparam logic [COMPONENT_BITS-1:0] COMP_MAX = {1'b0, {(COMPONENT_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] ONE_Q = QUO_BITS'(1) << (COMPONENT_BITS - 1);

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] bank_angle;
    logic signed [ANGLE_BITS-1:0] heading_angle;
    logic signed [ANGLE_BITS-1:0] attitude_angle;
  } in_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
  } out_t;

  // one rotator: x = cos, y = sin, z = residual phase
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  // rotator 0 = heading, 1 = attitude, 2 = bank
  typedef struct packed {
    logic           vld;
    rot_t [2:0]     rot;
  } cordic_t;

  typedef struct packed {
    logic                vld;
    logic [NW-1:0]       rem;
    logic [NW-1:0]       res;
    logic [3:0][QW-1:0]  q;
  } sqrt_t;

  typedef struct packed {
    logic                     vld;
    logic                     zero;
    logic [RW-1:0]            r;
    logic [3:0]               neg;
    logic [3:0][DW-1:0]       rem;
    logic [3:0][QUO_BITS-1:0] quo;
  } div_t;

  // Q2.30 product rounded to nearest, ties upward
  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b + ((2*CW)'(1) <<< (FRAC_BITS - 1));
    return CW'(p >>> FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

@@ rtl/euler_to_quaternion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline, in order: CORDIC cells, product/norm stages, square-root cells,
// the division set-up register, divide cells and the output register.
// Throughput: one transaction per cycle unless halted; every stage is a register cell.
// The pipeline only halts when its last stage and the output register are both
// full and the output is not taken.
// Reset (synchronous, rst_n low) clears all valid flags; data is not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Heading/attitude/bank angles to unit quaternion: CORDIC cell chain, product
// stages, square-root cell chain and division cell chain.
// ----------------------------------------------------------------------------
module euler_to_quaternion
  import e2q_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output wire logic in_ready,
  input  var in_t   in_data,
  output wire logic out_valid,
  input  wire logic out_ready,
  output var out_t  out_data
);

  localparam int ZSH = 31 - ANGLE_BITS;

  logic en;
  cordic_t cch [TRIG_STAGES+1];
  sqrt_t   sch [SQRT_STAGES+1];
  div_t    dch [QUO_BITS+1];

  // half-angle phase in 2^32 units per turn
  always_comb begin
    cch[0].vld = in_valid;
    cch[0].rot[0].z = CW'(in_data.heading_angle) <<< ZSH;
    cch[0].rot[1].z = CW'(in_data.attitude_angle) <<< ZSH;
    cch[0].rot[2].z = CW'(in_data.bank_angle) <<< ZSH;
    for (int a = 0; a < 3; a++) begin
      cch[0].rot[a].x = CORDIC_START;
      cch[0].rot[a].y = '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < TRIG_STAGES; k++) begin : g_cordic
      e2q_cordic_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en), .stage(5'(k)),
        .d_i(cch[k]), .d_o(cch[k+1])
      );
    end
  endgenerate

  // pair products
  logic m1_vld_r;
  logic signed [CW-1:0] c1c2_r, s1s2_r, s1c2_r, c1s2_r, c3_r, s3_r;
  // triple products
  logic m2_vld_r;
  logic signed [CW-1:0] t_r [8];
  // quaternion sums
  logic m3_vld_r;
  logic signed [QW-1:0] q3_r [4];
  // squares
  logic m4_vld_r;
  logic [NW-1:0] sq_r [4];
  logic signed [QW-1:0] q4_r [4];
  // pair sums of squares
  logic m5_vld_r;
  logic [NW-1:0] ps_r [2];
  logic signed [QW-1:0] q5_r [4];
  // norm squared
  logic m6_vld_r;
  logic [NW-1:0] n2_r;
  logic signed [QW-1:0] q6_r [4];

  logic [QW-1:0] mag4 [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag4[l] = q3_r[l][QW-1] ? QW'(-q3_r[l]) : QW'(q3_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
      m5_vld_r <= 1'b0;
      m6_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= cch[TRIG_STAGES].vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
      m5_vld_r <= m4_vld_r;
      m6_vld_r <= m5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1c2_r <= qmul(cch[TRIG_STAGES].rot[0].x, cch[TRIG_STAGES].rot[1].x);
      s1s2_r <= qmul(cch[TRIG_STAGES].rot[0].y, cch[TRIG_STAGES].rot[1].y);
      s1c2_r <= qmul(cch[TRIG_STAGES].rot[0].y, cch[TRIG_STAGES].rot[1].x);
      c1s2_r <= qmul(cch[TRIG_STAGES].rot[0].x, cch[TRIG_STAGES].rot[1].y);
      c3_r   <= cch[TRIG_STAGES].rot[2].x;
      s3_r   <= cch[TRIG_STAGES].rot[2].y;

      t_r[0] <= qmul(c1c2_r, c3_r);
      t_r[1] <= qmul(s1s2_r, s3_r);
      t_r[2] <= qmul(s1s2_r, c3_r);
      t_r[3] <= qmul(c1c2_r, s3_r);
      t_r[4] <= qmul(s1c2_r, c3_r);
      t_r[5] <= qmul(c1s2_r, s3_r);
      t_r[6] <= qmul(c1s2_r, c3_r);
      t_r[7] <= qmul(s1c2_r, s3_r);

      q3_r[0] <= QW'(t_r[0]) - QW'(t_r[1]);
      q3_r[1] <= QW'(t_r[2]) + QW'(t_r[3]);
      q3_r[2] <= QW'(t_r[4]) + QW'(t_r[5]);
      q3_r[3] <= QW'(t_r[6]) - QW'(t_r[7]);

      for (int l = 0; l < 4; l++) begin
        sq_r[l] <= NW'(mag4[l] * mag4[l]);
        q4_r[l] <= q3_r[l];
        q5_r[l] <= q4_r[l];
        q6_r[l] <= q5_r[l];
      end

      ps_r[0] <= sq_r[0] + sq_r[1];
      ps_r[1] <= sq_r[2] + sq_r[3];
      n2_r    <= ps_r[0] + ps_r[1];
    end
  end

  // square-root chain
  always_comb begin
    sch[0].vld = m6_vld_r;
    sch[0].rem = n2_r;
    sch[0].res = '0;
    for (int l = 0; l < 4; l++) begin
      sch[0].q[l] = q6_r[l];
    end
  end

  generate
    for (k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      e2q_sqrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en), .stage(5'(k)),
        .d_i(sch[k]), .d_o(sch[k+1])
      );
    end
  endgenerate

  // division set-up: numerator = |q| * 2^(N-1) + r/2
  div_t dv_nxt;
  div_t dv_r;
  logic [RW-1:0] root;
  logic [QW-1:0] magd;

  assign root = sch[SQRT_STAGES].res[RW-1:0];

  always_comb begin
    dv_nxt.vld  = sch[SQRT_STAGES].vld;
    dv_nxt.zero = (root == '0);
    dv_nxt.r    = root;
    for (int l = 0; l < 4; l++) begin
      magd = sch[SQRT_STAGES].q[l][QW-1] ? QW'(-sch[SQRT_STAGES].q[l])
                                          : QW'(sch[SQRT_STAGES].q[l]);
      dv_nxt.neg[l] = sch[SQRT_STAGES].q[l][QW-1];
      dv_nxt.rem[l] = (DW'(magd) << (COMPONENT_BITS - 1)) + DW'(root >> 1);
      dv_nxt.quo[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.vld <= 1'b0;
    end else if (en) begin
      dv_r.vld <= dv_nxt.vld;
    end
    if (en) begin
      dv_r.zero <= dv_nxt.zero;
      dv_r.r    <= dv_nxt.r;
      dv_r.neg  <= dv_nxt.neg;
      dv_r.rem  <= dv_nxt.rem;
      dv_r.quo  <= dv_nxt.quo;
    end
  end

  assign dch[0] = dv_r;

  generate
    for (k = 0; k < QUO_BITS; k++) begin : g_div
      e2q_div_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en), .shift(5'(QUO_BITS - 1 - k)),
        .d_i(dch[k]), .d_o(dch[k+1])
      );
    end
  endgenerate

  // saturation and sign
  logic [COMPONENT_BITS-1:0] comp [4];
  logic [QUO_BITS-1:0] qv;
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qv = dch[QUO_BITS].quo[l];
      if (!dch[QUO_BITS].neg[l]) begin
        comp[l] = (qv > QUO_BITS'(COMP_MAX)) ? COMP_MAX : qv[COMPONENT_BITS-1:0];
      end else begin
        comp[l] = (qv > ONE_Q) ? ONE_Q[COMPONENT_BITS-1:0]
                               : COMPONENT_BITS'(-qv);
      end
    end
  end

  // output register
  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;
  logic last_vld;
  logic load;

  assign last_vld = dch[QUO_BITS].vld;
  assign en       = !(last_vld && out_valid_r && !out_ready);
  assign load     = last_vld && en;
  assign in_ready = en;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (dch[QUO_BITS].zero) begin
        out_data_r.quat_w <= COMP_MAX;
        out_data_r.quat_x <= '0;
        out_data_r.quat_y <= '0;
        out_data_r.quat_z <= '0;
      end else begin
        out_data_r.quat_w <= comp[0];
        out_data_r.quat_x <= comp[1];
        out_data_r.quat_y <= comp[2];
        out_data_r.quat_z <= comp[3];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // an accepted transaction enters the first CORDIC cell
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> cch[1].vld)
    else $error("accepted transaction lost at pipeline entry");

  // a unit quaternion never comes out all zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_w != '0 || out_data.quat_x != '0 ||
                   out_data.quat_y != '0 || out_data.quat_z != '0))
    else $error("all quaternion components zero");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule
`default_nettype wire

@@ rtl/e2q_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One CORDIC micro-rotation for all three half angles, registered.
// ----------------------------------------------------------------------------
module e2q_cordic_cell
  import e2q_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic [4:0] stage,
  input  var cordic_t  d_i,
  output var cordic_t  d_o
);

  cordic_t d_nxt;
  cordic_t d_r;
  logic signed [CW-1:0] atan_v;

  assign atan_v = CW'(ATAN_TABLE[stage]);

  // rotate towards zero residual phase
  always_comb begin
    d_nxt = d_i;
    for (int a = 0; a < 3; a++) begin
      if (!d_i.rot[a].z[CW-1]) begin
        d_nxt.rot[a].x = d_i.rot[a].x - (d_i.rot[a].y >>> stage);
        d_nxt.rot[a].y = d_i.rot[a].y + (d_i.rot[a].x >>> stage);
        d_nxt.rot[a].z = d_i.rot[a].z - atan_v;
      end else begin
        d_nxt.rot[a].x = d_i.rot[a].x + (d_i.rot[a].y >>> stage);
        d_nxt.rot[a].y = d_i.rot[a].y - (d_i.rot[a].x >>> stage);
        d_nxt.rot[a].z = d_i.rot[a].z + atan_v;
      end
    end
  end

  // cell register; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
    if (en) begin
      d_r.rot <= d_nxt.rot;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

@@ rtl/e2q_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_sqrt_cell
// One result bit of the integer square root, quaternion sums carried along.
// ----------------------------------------------------------------------------
module e2q_sqrt_cell
  import e2q_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic [4:0] stage,
  input  var sqrt_t    d_i,
  output var sqrt_t    d_o
);

  sqrt_t d_nxt;
  sqrt_t d_r;
  logic [5:0]    sh;
  logic [NW-1:0] bitv;
  logic [NW-1:0] trial;

  assign sh    = 6'(NW - 2) - {stage, 1'b0};
  assign bitv  = NW'(1) << sh;
  assign trial = d_i.res + bitv;

  // restoring square root step
  always_comb begin
    d_nxt = d_i;
    if (d_i.rem >= trial) begin
      d_nxt.rem = d_i.rem - trial;
      d_nxt.res = (d_i.res >> 1) + bitv;
    end else begin
      d_nxt.res = d_i.res >> 1;
    end
  end

  // cell register; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
    if (en) begin
      d_r.rem <= d_nxt.rem;
      d_r.res <= d_nxt.res;
      d_r.q   <= d_nxt.q;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

@@ rtl/e2q_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_div_cell
// One quotient bit of the four-lane normalising division.
// ----------------------------------------------------------------------------
module e2q_div_cell
  import e2q_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic [4:0] shift,
  input  var div_t     d_i,
  output var div_t     d_o
);

  div_t d_nxt;
  div_t d_r;
  logic [DW-1:0] dsor;

  assign dsor = DW'(d_i.r) << shift;

  // restoring division step on each lane
  always_comb begin
    d_nxt = d_i;
    for (int l = 0; l < 4; l++) begin
      if (d_i.rem[l] >= dsor) begin
        d_nxt.rem[l] = d_i.rem[l] - dsor;
        d_nxt.quo[l] = {d_i.quo[l][QUO_BITS-2:0], 1'b1};
      end else begin
        d_nxt.quo[l] = {d_i.quo[l][QUO_BITS-2:0], 1'b0};
      end
    end
  end

  // cell register; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
    if (en) begin
      d_r.zero <= d_nxt.zero;
      d_r.r    <= d_nxt.r;
      d_r.neg  <= d_nxt.neg;
      d_r.rem  <= d_nxt.rem;
      d_r.quo  <= d_nxt.quo;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

@@ dv/euler_to_quaternion_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angle to quaternion converter testbench
// Drives heading/attitude/bank angle transactions through the valid/ready
// input, predicts each unit quaternion with an independent bit-accurate
// CORDIC, product, root and divide model, and compares every result in order.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;
  import e2q_pkg::*;

  localparam int LATENCY     = 80;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t quat_queue [$];
  int   err_count = 0;
  int   sent_count = 0;
  int   seen_count = 0;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;
  bit   sender_busy = 1'b0;

  euler_to_quaternion uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor shift for signed values (>>> on longint already floors)
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return fshr(a * b + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
  endfunction

  // Half-angle sine/cosine by CORDIC in Q2.30
  task automatic half_sincos(input logic [ANGLE_BITS-1:0] ang,
                             output longint c, output longint s);
    logic [31:0] full;
    logic [31:0] ph;
    longint z, x, y, nx;
    full = {ang, {(32 - ANGLE_BITS){1'b0}}};
    ph = {full[31], full[31:1]};
    z = longint'(signed'(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i);
        y  = y + fshr(x, i);
        z  = z - longint'(ATAN_TABLE[i]);
      end else begin
        nx = x + fshr(y, i);
        y  = y - fshr(x, i);
        z  = z + longint'(ATAN_TABLE[i]);
      end
      x = nx;
    end
    c = x;
    s = y;
  endtask

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [COMPONENT_BITS-1:0] scale_comp(longint v, logic [63:0] r);
    logic [63:0] one, mag, q;
    one = 64'd1 << (COMPONENT_BITS - 1);
    mag = (v >= 0) ? v : -v;
    q = ((mag << (COMPONENT_BITS - 1)) + r / 2) / r;
    if (v >= 0) return (q > one - 1) ? COMPONENT_BITS'(one - 1) : COMPONENT_BITS'(q);
    if (q > one) q = one;
    return COMPONENT_BITS'(-q);
  endfunction

  task automatic predict_quat(input in_t a, output out_t e);
    longint c1, s1, c2, s2, c3, s3;
    longint q [4];
    logic [63:0] n2, r, m;
    half_sincos(a.heading_angle, c1, s1);
    half_sincos(a.attitude_angle, c2, s2);
    half_sincos(a.bank_angle, c3, s3);
    q[0] = qprod(qprod(c1, c2), c3) - qprod(qprod(s1, s2), s3);
    q[1] = qprod(qprod(s1, s2), c3) + qprod(qprod(c1, c2), s3);
    q[2] = qprod(qprod(s1, c2), c3) + qprod(qprod(c1, s2), s3);
    q[3] = qprod(qprod(c1, s2), c3) - qprod(qprod(s1, c2), s3);
    n2 = 0;
    for (int k = 0; k < 4; k++) begin
      m = (q[k] >= 0) ? q[k] : -q[k];
      n2 = n2 + m * m;
    end
    r = int_root(n2);
    if (r == 0) begin
      e = '0;
      e.quat_w = COMP_MAX;
    end else begin
      e.quat_w = scale_comp(q[0], r);
      e.quat_x = scale_comp(q[1], r);
      e.quat_y = scale_comp(q[2], r);
      e.quat_z = scale_comp(q[3], r);
    end
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Send one angle transaction, predicting its quaternion on acceptance.
  // Valid stays high into the next call, so back-to-back transactions
  // need no deassertion; the caller drops it when the stream ends.
  task automatic send_angles(input logic [15:0] b, input logic [15:0] h,
                             input logic [15:0] a, input bit gaps);
    in_t  item;
    out_t e;
    int   g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    item.bank_angle = b;
    item.heading_angle = h;
    item.attitude_angle = a;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_quat(item, e);
    quat_queue.push_back(e);
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, and a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || !sender_busy;
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_count++;
      if (quat_queue.size() == 0) begin
        $error("quaternion result with no transaction pending");
        err_count++;
      end else begin
        out_t e;
        e = quat_queue.pop_front();
        if (out_data.quat_w !== e.quat_w) begin
          $error("quat_w expected %0d actual %0d", e.quat_w, out_data.quat_w);
          err_count++;
        end
        if (out_data.quat_x !== e.quat_x) begin
          $error("quat_x expected %0d actual %0d", e.quat_x, out_data.quat_x);
          err_count++;
        end
        if (out_data.quat_y !== e.quat_y) begin
          $error("quat_y expected %0d actual %0d", e.quat_y, out_data.quat_y);
          err_count++;
        end
        if (out_data.quat_z !== e.quat_z) begin
          $error("quat_z expected %0d actual %0d", e.quat_z, out_data.quat_z);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else if (rst_n && !hold_off) idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Extremes of every angle, each axis alone and the half-turn cases
  task automatic test_directed();
    logic [15:0] ext [6];
    ext = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000};
    for (int i = 0; i < 6; i++) send_angles(ext[i], 16'h0, 16'h0, 1'b0);
    for (int i = 0; i < 6; i++) send_angles(16'h0, ext[i], 16'h0, 1'b0);
    for (int i = 0; i < 6; i++) send_angles(16'h0, 16'h0, ext[i], 1'b0);
    send_angles(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_angles(16'h5555, 16'hAAAA, 16'hC000, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 120; i++)
          send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
        in_valid <= 1'b0;
      end
    join
    @(negedge clk);
  endtask

  // Random angles with random gaps; a share near the special values
  task automatic test_random();
    logic [15:0] v [3];
    for (int i = 0; i < 1100; i++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 7))
          0: v[k] = 16'(32'h8000 + $urandom_range(0, 2) - 1);
          1: v[k] = 16'($urandom_range(0, 2) - 1);
          default: v[k] = 16'($urandom());
        endcase
      end
      send_angles(v[0], v[1], v[2], 1'b1);
    end
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    sender_busy = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    sender_busy = 1'b0;
    guard = 0;
    while (quat_queue.size() != 0 && guard < STALL_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
    if (quat_queue.size() != 0) begin
      $error("%0d quaternion results never arrived", quat_queue.size());
      err_count++;
    end
    $display("Sent %0d angle transactions, checked %0d quaternions, %0d errors",
             sent_count, seen_count, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/e2q_pkg.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_sqrt_cell.sv
rtl/e2q_div_cell.sv
rtl/euler_to_quaternion.sv
dv/euler_to_quaternion_tb.sv
